/* rtl/core/gifd_pkg.sv */
// ----------------------------------------------------------------------------
// gifd_pkg
// Shared constants and types for the GIF LZW pixel decoder.
// ----------------------------------------------------------------------------
package gifd_pkg;

  localparam int TABLE_SIZE_DEF    = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [2:0] REG_MIN_CODE = 3'd0;
  localparam logic [2:0] REG_WIDTH    = 3'd1;
  localparam logic [2:0] REG_HEIGHT   = 3'd2;
  localparam logic [2:0] REG_INTERL   = 3'd3;
  localparam logic [2:0] REG_SQUASH   = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [7:0]  pixel_index;
    logic [15:0] pixel_x;
    logic [15:0] pixel_row;
    logic        need_byte;
    logic        finished;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic restart;
    logic do_byte;
    logic do_pop;
    logic do_decode;
    logic do_skip;
    logic walk_step;
    logic walk_end;
    logic emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stack_empty;
    logic can_decode;
    logic decode_walks;
    logic walk_more;
  } dp_stat_t;

endpackage

/* rtl/core/gifd_if.sv */
// ----------------------------------------------------------------------------
// gifd_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface gifd_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/gifd_ram.sv */
// ----------------------------------------------------------------------------
// gifd_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gifd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/gifd_ctrl.sv */
// ----------------------------------------------------------------------------
// gifd_ctrl
// Sequencer: accepts a word, runs the chain walk, presents the result.
// ----------------------------------------------------------------------------
module gifd_ctrl
  import gifd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       acc;

  assign in_ready  = (state_r == ST_IDLE) && !cfg_wr;
  assign out_valid = (state_r == ST_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cmd.restart = cfg_wr;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_op == OP_BYTE) begin
            cmd.do_byte = 1'b1;
            state_nxt   = ST_OUT;
          end else if (!stat.stack_empty) begin
            cmd.do_pop = 1'b1;
            state_nxt  = ST_READ;
          end else if (stat.can_decode) begin
            cmd.do_decode = 1'b1;
            state_nxt     = stat.decode_walks ? ST_WALK : ST_OUT;
          end else begin
            cmd.do_skip = 1'b1;
            state_nxt   = ST_OUT;
          end
        end
      end
      ST_READ: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_WALK: begin
        if (stat.walk_more) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.walk_end = 1'b1;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

/* rtl/core/gifd_dp.sv */
// ----------------------------------------------------------------------------
// gifd_dp
// Datapath: bit buffer, code tables, string stack and pixel position.
// ----------------------------------------------------------------------------
module gifd_dp
  import gifd_pkg::*;
#(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  min_code_size,
  input  logic [15:0] image_width,
  input  logic [15:0] image_height,
  input  logic        interlaced,
  input  logic        squash_mode,
  output out_word_t   result
);
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int SW = AW + 1;

  logic [19:0] bbuf_r, bbuf_nxt;
  logic [4:0]  bcnt_r, bcnt_nxt;
  logic [7:0]  blk_r, blk_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [SW-1:0] next_r, next_nxt, top_r, top_nxt, sp_r, sp_nxt;
  logic [11:0] old_r, old_nxt, code_r, code_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic        ac_r, ac_nxt, done_r, done_nxt;
  logic [15:0] x_r, x_nxt, y_r, y_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [2:0]  pass_r, pass_nxt;
  logic [11:0] c_new_r, c_new_nxt;
  out_word_t   res_r, res_nxt;

  logic [3:0]  em;
  logic [8:0]  clr;
  logic [11:0] c_raw, c_code;
  logic [11:0] cmask;

  logic          st_we, tb_we;
  logic [AW-1:0] st_wa, st_ra, tb_wa, tb_ra;
  logic [7:0]    st_wd, st_rd, sfx_rd;
  logic [11:0]   pfx_rd;

  gifd_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_stack (
    .clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  gifd_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_sfx (
    .clk, .we(tb_we), .waddr(tb_wa), .wdata(fc_nxt), .raddr(tb_ra), .rdata(sfx_rd));
  gifd_ram #(.WIDTH(12), .DEPTH(TABLE_SIZE)) u_pfx (
    .clk, .we(tb_we), .waddr(tb_wa), .wdata(old_r), .raddr(tb_ra), .rdata(pfx_rd));

  always_comb begin
    em = min_code_size;
    if (min_code_size < 4'd2) em = 4'd2;
    if (min_code_size > 4'd8) em = 4'd8;
  end
  assign clr    = 9'd1 << em;
  assign cmask  = 12'((13'd1 << cw_r) - 13'd1);
  assign c_raw  = bbuf_r[11:0] & cmask;
  assign c_code = (SW'(c_raw) >= next_r) ? old_r : c_raw;

  assign stat.stack_empty  = (sp_r == '0);
  assign stat.can_decode   = !done_r && (bcnt_r >= {1'b0, cw_r});
  assign stat.decode_walks = !(c_raw == 12'(clr) || c_raw == 12'(clr) + 12'd1 || ac_r);
  assign stat.walk_more    = (code_r >= 12'(clr) + 12'd2) && (sp_r < SW'(TABLE_SIZE - 1));

  assign tb_ra = cmd.do_decode ? AW'(c_code) : AW'(pfx_rd);
  assign st_ra = AW'(sp_r - SW'(1));

  // pixel placement on (x_r,y_r) and position advance
  logic        pl_en, pl_edge, pl_ok;
  logic [7:0]  pl_idx;
  logic [16:0] y_adv;
  logic [2:0]  p_a;
  logic [4:0]  s_a;

  function automatic logic [16:0] next_row(input logic [2:0] p);
    next_row = 17'(5'd8 >> p);
  endfunction

  always_comb begin
    bbuf_nxt = bbuf_r; bcnt_nxt = bcnt_r; blk_nxt = blk_r; cw_nxt = cw_r;
    next_nxt = next_r; top_nxt = top_r; sp_nxt = sp_r; old_nxt = old_r;
    code_nxt = code_r; fc_nxt = fc_r; ac_nxt = ac_r; done_nxt = done_r;
    x_nxt = x_r; y_nxt = y_r; step_nxt = step_r; pass_nxt = pass_r;
    c_new_nxt = c_new_r; res_nxt = res_r;
    st_we = 1'b0; st_wa = AW'(sp_r); st_wd = '0;
    tb_we = 1'b0; tb_wa = AW'(next_r);
    pl_en = 1'b0; pl_edge = 1'b0; pl_idx = '0;
    pl_ok = 1'b0; y_adv = '0; p_a = pass_r; s_a = step_r;

    if (cmd.do_byte || cmd.do_pop || cmd.do_decode || cmd.do_skip) begin
      res_nxt = '0;
    end

    if (cmd.do_byte && !done_r) begin
      if (blk_r == 8'd0) begin
        if (data_byte == 8'd0) done_nxt = 1'b1;
        else blk_nxt = data_byte;
      end else begin
        blk_nxt = blk_r - 8'd1;
        if (bcnt_r <= 5'd12) begin
          bbuf_nxt = bbuf_r | (20'(data_byte) << bcnt_r);
          bcnt_nxt = bcnt_r + 5'd8;
        end
      end
    end

    if (cmd.do_pop) begin
      sp_nxt = sp_r - SW'(1);
    end
    if (cmd.emit) begin
      pl_en = 1'b1; pl_edge = 1'b1; pl_idx = st_rd;
    end

    if (cmd.do_decode) begin
      bbuf_nxt = bbuf_r >> cw_r;
      bcnt_nxt = bcnt_r - {1'b0, cw_r};
      if (c_raw == 12'(clr)) begin
        cw_nxt = em + 4'd1;
        next_nxt = SW'(clr) + SW'(2);
        top_nxt = SW'(1) << (em + 4'd1);
        ac_nxt = 1'b1;
      end else if (c_raw == 12'(clr) + 12'd1) begin
        done_nxt = 1'b1;
      end else if (ac_r) begin
        ac_nxt = 1'b0;
        old_nxt = (SW'(c_raw) >= next_r) ? 12'd0 : c_raw;
        fc_nxt = old_nxt[7:0];
        pl_en = 1'b1; pl_idx = old_nxt[7:0];
      end else begin
        c_new_nxt = c_raw;
        code_nxt = c_code;
        if (SW'(c_raw) >= next_r) begin
          st_we = 1'b1; st_wd = fc_r; sp_nxt = sp_r + SW'(1);
        end
      end
    end

    if (cmd.walk_step) begin
      st_we = 1'b1; st_wd = sfx_rd; sp_nxt = sp_r + SW'(1);
      code_nxt = pfx_rd;
    end

    if (cmd.walk_end) begin
      if (sp_r < SW'(TABLE_SIZE)) begin
        st_we = 1'b1; st_wd = code_r[7:0]; sp_nxt = sp_r + SW'(1);
      end
      fc_nxt = code_r[7:0];
      if (next_r < top_r && next_r < SW'(TABLE_SIZE)) begin
        tb_we = 1'b1;
        next_nxt = next_r + SW'(1);
      end
      old_nxt = c_new_r;
      if (next_nxt >= top_r && cw_r < 4'(MAX_CODE_BITS)) begin
        top_nxt = top_r << 1;
        cw_nxt = cw_r + 4'd1;
      end
    end

    if (pl_en) begin
      pl_ok = (pass_r < 3'd4) && (x_r < image_width) && (y_r < image_height);
      if (pl_ok && squash_mode)
        pl_ok = (pl_edge && (17'(y_r) + 17'd1 == 17'(image_height))) || (x_r[0] == y_r[0]);
      if (pl_ok) begin
        res_nxt.pixel_valid = 1'b1;
        res_nxt.pixel_index = pl_idx;
        res_nxt.pixel_x = x_r;
        res_nxt.pixel_row = squash_mode ? (y_r >> 1) : y_r;
      end
      if (pass_r < 3'd4) begin
        if (17'(x_r) + 17'd1 < 17'(image_width)) begin
          x_nxt = x_r + 16'd1;
        end else begin
          x_nxt = '0;
          y_adv = 17'(y_r) + 17'(step_r);
          // interlace passes: at most four skips, unrolled
          for (int i = 0; i < 4; i++) begin
            if (y_adv >= 17'(image_height) && p_a < 3'd4) begin
              if (!interlaced) p_a = 3'd4;
              else begin
                p_a = p_a + 3'd1;
                if (p_a < 3'd4) begin
                  y_adv = next_row(p_a);
                  s_a = 5'(5'd16 >> p_a);
                end
              end
            end
          end
          pass_nxt = p_a; step_nxt = s_a; y_nxt = y_adv[15:0];
        end
      end
    end

    if (cmd.restart) begin
      sp_nxt = '0; bbuf_nxt = '0; bcnt_nxt = '0; blk_nxt = '0;
      cw_nxt = em + 4'd1; next_nxt = SW'(clr) + SW'(2); top_nxt = SW'(1) << (em + 4'd1);
      old_nxt = '0; fc_nxt = '0; ac_nxt = 1'b0; done_nxt = 1'b0;
      x_nxt = '0; y_nxt = '0; pass_nxt = '0; step_nxt = interlaced ? 5'd8 : 5'd1;
    end

    res_nxt.finished  = done_nxt;
    res_nxt.need_byte = !done_nxt && (sp_nxt == '0) && (bcnt_nxt < {1'b0, cw_nxt});
  end

  assign result = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bbuf_r <= '0; bcnt_r <= '0; blk_r <= '0; cw_r <= 4'd9;
      next_r <= SW'(258); top_r <= SW'(512); sp_r <= '0;
      old_r <= '0; fc_r <= '0; ac_r <= 1'b0; done_r <= 1'b0;
      x_r <= '0; y_r <= '0; step_r <= 5'd1; pass_r <= '0;
    end else begin
      bbuf_r <= bbuf_nxt; bcnt_r <= bcnt_nxt; blk_r <= blk_nxt; cw_r <= cw_nxt;
      next_r <= next_nxt; top_r <= top_nxt; sp_r <= sp_nxt;
      old_r <= old_nxt; fc_r <= fc_nxt; ac_r <= ac_nxt; done_r <= done_nxt;
      x_r <= x_nxt; y_r <= y_nxt; step_r <= step_nxt; pass_r <= pass_nxt;
    end
    code_r <= code_nxt;
    c_new_r <= c_new_nxt;
    res_r <= res_nxt;
  end
endmodule

/* rtl/core/gif_lzw_pixel_decoder.sv */
// ----------------------------------------------------------------------------
// gif_lzw_pixel_decoder
// GIF LZW decoder: raw image-data bytes in, one result word per input word.
// A byte, empty drain, clear, end or first code is presented directly; a pop
// reads the stack first; other codes walk their chain. One word in flight at a
// time; the next is taken once the result has left, and not during a register
// write. Reset (rst_n, synchronous) and writes to registers 0-4 restart the
// frame state; table and stack stay undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
module gif_lzw_pixel_decoder
  import gifd_pkg::*;
#(
  parameter int TABLE_SIZE    = TABLE_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gifd_if.sink        in_ch,
  gifd_if.source      out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [3:0]  min_r;
  logic [15:0] wid_r, hgt_r;
  logic        int_r, sq_r, cfg_wr;
  logic [2:0]  ridx;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  in_word_t    iw;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign ridx   = cfg_paddr[4:2];
  assign iw     = in_ch.payload;

  always_comb begin
    case (ridx)
      REG_MIN_CODE: cfg_prdata = 32'(min_r);
      REG_WIDTH:    cfg_prdata = 32'(wid_r);
      REG_HEIGHT:   cfg_prdata = 32'(hgt_r);
      REG_INTERL:   cfg_prdata = 32'(int_r);
      REG_SQUASH:   cfg_prdata = 32'(sq_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= 4'd8; wid_r <= 16'd1; hgt_r <= 16'd1; int_r <= 1'b0; sq_r <= 1'b0;
    end else if (cfg_wr && cfg_paddr[1:0] == 2'b00) begin
      case (ridx)
        REG_MIN_CODE: min_r <= cfg_pwdata[3:0];
        REG_WIDTH:    wid_r <= cfg_pwdata[15:0];
        REG_HEIGHT:   hgt_r <= cfg_pwdata[15:0];
        REG_INTERL:   int_r <= cfg_pwdata[0];
        REG_SQUASH:   sq_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  logic restart_r;
  always_ff @(posedge clk) begin
    if (!rst_n) restart_r <= 1'b0;
    else restart_r <= cfg_wr && cfg_paddr[1:0] == 2'b00 && ridx <= REG_SQUASH;
  end

  gifd_ctrl u_ctrl (
    .clk, .rst_n, .cfg_wr(cfg_wr || restart_r),
    .in_valid(in_ch.valid), .in_op(iw.op), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .stat, .cmd);

  dp_cmd_t cmd_dp;
  always_comb begin
    cmd_dp = cmd;
    cmd_dp.restart = restart_r;
  end

  gifd_dp #(.TABLE_SIZE(TABLE_SIZE), .MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
    .clk, .rst_n, .cmd(cmd_dp), .stat, .data_byte(iw.data_byte),
    .min_code_size(min_r), .image_width(wid_r), .image_height(hgt_r),
    .interlaced(int_r), .squash_mode(sq_r), .result(out_ch.payload));
endmodule

/* rtl/core/gifd_checker.sv */
// ----------------------------------------------------------------------------
// gifd_checker
// Port-level checks on the decoder handshakes and result words.
// ----------------------------------------------------------------------------
module gifd_checker
  import gifd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_payload
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result dropped or changed while stalled");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("new word taken with result pending");
  a_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload.pixel_valid |->
      out_payload.pixel_index == 8'd0 && out_payload.pixel_x == 16'd0 &&
      out_payload.pixel_row == 16'd0)
    else $error("pixel fields set without a pixel");
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.finished |-> !out_payload.need_byte)
    else $error("need_byte while finished");
endmodule

bind gif_lzw_pixel_decoder gifd_checker u_chk (
  .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload));
